>>> hw/rtl/fwcb_pkg.sv
// ----------------------------------------------------------------------------
// fwcb_pkg
// Shared constants, codes and controller/datapath types of the failure window
// circuit breaker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwcb_pkg;

  localparam int unsigned AGENT_COUNT   = 16;
  localparam int unsigned FAILURE_SLOTS = 8;

  localparam int unsigned AGENT_W  = (AGENT_COUNT > 1) ? $clog2(AGENT_COUNT) : 1;
  localparam int unsigned AIDX_W   = (AGENT_W > 4) ? AGENT_W : 4;
  localparam int unsigned SLOT_W   = (FAILURE_SLOTS > 1) ? $clog2(FAILURE_SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(FAILURE_SLOTS + 1);
  localparam int unsigned SUM_W    = SLOT_W + 2;
  localparam int unsigned TH_W     = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned MEM_AW   = AGENT_W + SLOT_W;
  localparam int unsigned MEM_DEPTH = 1 << MEM_AW;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THR_W    = 4;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [TIME_W-1:0] WINDOW_RESET   = 32'd60000;
  localparam logic [THR_W-1:0]  THRESH_RESET   = 4'd3;
  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd30000;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_THRESH   = 2'd1;
  localparam logic [1:0] REG_COOLDOWN = 2'd2;

  localparam logic [1:0] CMD_SUCCESS = 2'd0;
  localparam logic [1:0] CMD_FAILURE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_UPDATE,
    ST_RESULT
  } fsm_state_e;

  typedef struct packed {
    logic load;
    logic prune_rd;
    logic prune_step;
    logic update;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_prune;
    logic expired;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/failure_window_circuit_breaker.sv
// ----------------------------------------------------------------------------
// failure_window_circuit_breaker
// Per-agent circuit breaker over a sliding window of failure times.
// ----------------------------------------------------------------------------
// Each item names an agent, a command (success, failure, query) and the time
// in ms; it returns one result item with the open flag, the failure count left
// in the window, the remaining cooldown and the raw tripped mark. One item is
// in flight at a time. After acceptance the expired failures of that agent
// are dropped one at a time, each with one read of the single-port failure
// time memory and one compare, until a live failure stops the prune or none
// is left (0 to FAILURE_SLOTS are dropped); then the command is applied and
// the result register is loaded. The next item is accepted in the cycle after
// the result register is loaded. A pending result does not block the next
// item from being accepted. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module failure_window_circuit_breaker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [fwcb_pkg::APB_AW-1:0]         paddr,
  input  wire logic [fwcb_pkg::APB_DW-1:0]         pwdata,
  output logic      [fwcb_pkg::APB_DW-1:0]         prdata,
  output logic                                     pready,
  // items in
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [1:0] command, [5:2] agent_index, [37:6] now_time_ms, [39:38] zero
  input  wire logic [fwcb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // results out
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] breaker_open, [4:1] recent_failure_count, [36:5] cooldown_left_ms,
  // [37] tripped_flag, [39:38] zero
  output logic      [fwcb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic [fwcb_pkg::TIME_W-1:0] window_q;
  logic [fwcb_pkg::THR_W-1:0]  thresh_q;
  logic [fwcb_pkg::TIME_W-1:0] cooldown_q;
  logic                        wr_en;

  fwcb_pkg::dp_cmd_t dp_cmd;
  fwcb_pkg::dp_sts_t dp_sts;

  logic                        res_open;
  logic [3:0]                  res_count;
  logic [fwcb_pkg::TIME_W-1:0] res_left;
  logic                        res_trip;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= fwcb_pkg::WINDOW_RESET;
      thresh_q   <= fwcb_pkg::THRESH_RESET;
      cooldown_q <= fwcb_pkg::COOLDOWN_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        fwcb_pkg::REG_WINDOW:   window_q   <= pwdata;
        fwcb_pkg::REG_THRESH:   thresh_q   <= pwdata[fwcb_pkg::THR_W-1:0];
        fwcb_pkg::REG_COOLDOWN: cooldown_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fwcb_pkg::REG_WINDOW:   prdata = window_q;
      fwcb_pkg::REG_THRESH:   prdata = fwcb_pkg::APB_DW'(thresh_q);
      fwcb_pkg::REG_COOLDOWN: prdata = cooldown_q;
      default:                prdata = '0;
    endcase
  end

  fwcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  fwcb_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (dp_cmd),
    .sts_o                  (dp_sts),
    .command_i              (s_axis_tdata[1:0]),
    .agent_index_i          (s_axis_tdata[5:2]),
    .now_time_ms_i          (s_axis_tdata[37:6]),
    .window_length_ms_i     (window_q),
    .trip_threshold_i       (thresh_q),
    .cooldown_length_ms_i   (cooldown_q),
    .out_ready_i            (m_axis_tready),
    .out_valid_o            (m_axis_tvalid),
    .breaker_open_o         (res_open),
    .recent_failure_count_o (res_count),
    .cooldown_left_ms_o     (res_left),
    .tripped_flag_o         (res_trip)
  );

  assign m_axis_tdata = {2'b00, res_trip, res_left, res_count, res_open};

endmodule

`default_nettype wire

>>> hw/rtl/fwcb_ctrl.sv
// ----------------------------------------------------------------------------
// fwcb_ctrl
// Sequencer for one item: load agent entry, prune expired failures one at a
// time, apply the command, then hand the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwcb_ctrl (
  input  wire                logic            clk_i,
  input  wire                logic            rst_ni,
  input  wire                logic            in_valid_i,
  output logic                                in_ready_o,
  input  fwcb_pkg::dp_sts_t                   sts_i,
  output fwcb_pkg::dp_cmd_t                   cmd_o
);

  fwcb_pkg::fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fwcb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwcb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fwcb_pkg::ST_PRUNE_RD;
        end
      end
      fwcb_pkg::ST_PRUNE_RD: begin
        if (sts_i.skip_prune) begin
          state_d = fwcb_pkg::ST_UPDATE;
        end else begin
          state_d = fwcb_pkg::ST_PRUNE_CHK;
        end
      end
      fwcb_pkg::ST_PRUNE_CHK: begin
        if (sts_i.expired) begin
          state_d = fwcb_pkg::ST_PRUNE_RD;
        end else begin
          state_d = fwcb_pkg::ST_UPDATE;
        end
      end
      fwcb_pkg::ST_UPDATE: begin
        state_d = fwcb_pkg::ST_RESULT;
      end
      fwcb_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = fwcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fwcb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      fwcb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fwcb_pkg::ST_PRUNE_RD: begin
        cmd_o.prune_rd = ~sts_i.skip_prune;
      end
      fwcb_pkg::ST_PRUNE_CHK: begin
        cmd_o.prune_step = sts_i.expired;
      end
      fwcb_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      fwcb_pkg::ST_RESULT: begin
        cmd_o.result_load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/fwcb_dp.sv
// ----------------------------------------------------------------------------
// fwcb_dp
// Per-agent breaker state, failure time memory, prune compare, command update
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwcb_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  fwcb_pkg::dp_cmd_t                           cmd_i,
  output fwcb_pkg::dp_sts_t                           sts_o,
  input  wire logic [1:0]                             command_i,
  input  wire logic [3:0]                             agent_index_i,
  input  wire logic [fwcb_pkg::TIME_W-1:0]            now_time_ms_i,
  input  wire logic [fwcb_pkg::TIME_W-1:0]            window_length_ms_i,
  input  wire logic [fwcb_pkg::THR_W-1:0]             trip_threshold_i,
  input  wire logic [fwcb_pkg::TIME_W-1:0]            cooldown_length_ms_i,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic                                        breaker_open_o,
  output logic [3:0]                                  recent_failure_count_o,
  output logic [fwcb_pkg::TIME_W-1:0]                 cooldown_left_ms_o,
  output logic                                        tripped_flag_o
);

  localparam int unsigned AW  = fwcb_pkg::AGENT_W;
  localparam int unsigned SW  = fwcb_pkg::SLOT_W;
  localparam int unsigned CW  = fwcb_pkg::CNT_W;
  localparam int unsigned TW  = fwcb_pkg::TIME_W;
  localparam int unsigned NA  = fwcb_pkg::AGENT_COUNT;
  localparam int unsigned NS  = fwcb_pkg::FAILURE_SLOTS;
  localparam int unsigned XW  = fwcb_pkg::AIDX_W;
  localparam int unsigned UW  = fwcb_pkg::SUM_W;
  localparam int unsigned HW  = fwcb_pkg::TH_W;

  // per-agent state
  logic          mark_q     [NA];
  logic [TW-1:0] cend_arr_q [NA];
  logic [CW-1:0] fcnt_arr_q [NA];
  logic [SW-1:0] old_arr_q  [NA];

  // failure time store
  logic [TW-1:0] ftime_mem [fwcb_pkg::MEM_DEPTH];
  logic [TW-1:0] rdata_q;

  // working copy of one item
  logic [1:0]    op_q;
  logic [AW-1:0] agent_q;
  logic [TW-1:0] now_q;
  logic          in_range_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] oldest_q;
  logic          tripped_q;
  logic [TW-1:0] cend_q;

  logic          out_valid_q;
  logic          open_q;
  logic [3:0]    count_out_q;
  logic [TW-1:0] left_q;
  logic          trip_out_q;

  logic [XW-1:0] agent_ext;
  logic [AW-1:0] agent_in;
  logic          in_range_in;
  logic [SW-1:0] oldest_inc;
  logic [UW-1:0] slot_sum;
  logic [SW-1:0] slot_new;
  logic          full;
  logic [CW-1:0] cnt_new;
  logic [SW-1:0] oldest_new;
  logic [SW-1:0] wr_slot;
  logic          trip_new;
  logic [TW-1:0] cend_new;
  logic [TW-1:0] remaining;
  logic          open_now;

  assign agent_ext   = XW'(agent_index_i);
  assign agent_in    = agent_ext[AW-1:0];
  assign in_range_in = (XW+1)'(agent_ext) < (XW+1)'(NA);

  assign oldest_inc = (oldest_q == SW'(NS - 1)) ? '0 : oldest_q + SW'(1);

  always_comb begin
    slot_sum = UW'(oldest_q) + UW'(cnt_q);
    if (slot_sum >= UW'(NS)) begin
      slot_sum = slot_sum - UW'(NS);
    end
    slot_new = slot_sum[SW-1:0];
  end

  assign full = cnt_q >= CW'(NS);

  always_comb begin
    cnt_new    = cnt_q;
    oldest_new = oldest_q;
    wr_slot    = slot_new;
    trip_new   = tripped_q;
    cend_new   = cend_q;
    case (op_q)
      fwcb_pkg::CMD_SUCCESS: begin
        cnt_new    = '0;
        oldest_new = '0;
        trip_new   = 1'b0;
        cend_new   = '0;
      end
      fwcb_pkg::CMD_FAILURE: begin
        if (full) begin
          wr_slot    = oldest_q;
          oldest_new = oldest_inc;
        end else begin
          cnt_new = cnt_q + CW'(1);
        end
        if (tripped_q || (HW'(cnt_new) >= HW'(trip_threshold_i))) begin
          trip_new = 1'b1;
          cend_new = now_q + cooldown_length_ms_i;
        end
      end
      default: begin
        cnt_new = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        mark_q[i]     <= 1'b0;
        cend_arr_q[i] <= '0;
        fcnt_arr_q[i] <= '0;
        old_arr_q[i]  <= '0;
      end
    end else if (cmd_i.update && in_range_q) begin
      mark_q[agent_q]     <= trip_new;
      cend_arr_q[agent_q] <= cend_new;
      fcnt_arr_q[agent_q] <= cnt_new;
      old_arr_q[agent_q]  <= oldest_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && in_range_q && (op_q == fwcb_pkg::CMD_FAILURE)) begin
      ftime_mem[{agent_q, wr_slot}] <= now_q;
    end
    if (cmd_i.prune_rd) begin
      rdata_q <= ftime_mem[{agent_q, oldest_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= command_i;
      agent_q    <= agent_in;
      now_q      <= now_time_ms_i;
      in_range_q <= in_range_in;
      cnt_q      <= fcnt_arr_q[agent_in];
      oldest_q   <= old_arr_q[agent_in];
      tripped_q  <= mark_q[agent_in];
      cend_q     <= cend_arr_q[agent_in];
    end else if (cmd_i.prune_step) begin
      cnt_q    <= cnt_q - CW'(1);
      oldest_q <= oldest_inc;
    end else if (cmd_i.update) begin
      cnt_q     <= cnt_new;
      oldest_q  <= oldest_new;
      tripped_q <= trip_new;
      cend_q    <= cend_new;
    end
  end

  assign remaining = cend_q - now_q;
  assign open_now  = tripped_q && (remaining != '0) && (remaining <= cooldown_length_ms_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      open_q      <= in_range_q && open_now;
      count_out_q <= in_range_q ? 4'(cnt_q) : 4'd0;
      left_q      <= (in_range_q && open_now) ? remaining : '0;
      trip_out_q  <= in_range_q && tripped_q;
    end
  end

  assign sts_o.skip_prune = ~in_range_q || (cnt_q == '0);
  assign sts_o.expired    = (now_q - rdata_q) >= window_length_ms_i;
  assign sts_o.out_free   = ~out_valid_q || out_ready_i;

  assign out_valid_o            = out_valid_q;
  assign breaker_open_o         = open_q;
  assign recent_failure_count_o = count_out_q;
  assign cooldown_left_ms_o     = left_q;
  assign tripped_flag_o         = trip_out_q;

endmodule

`default_nettype wire
